// ===== hw/rtl/cht_pkg.sv =====
// ----------------------------------------------------------------------------
// Chained hash table package
// Shared constants and command codes.
// ----------------------------------------------------------------------------
package cht_pkg;

  localparam int unsigned DefBuckets = 256;
  localparam int unsigned DefNodes   = 1024;

  localparam logic [1:0] CMD_PUT    = 2'd0;
  localparam logic [1:0] CMD_GET    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

endpackage

// ===== hw/rtl/cht_ram.sv =====
// ----------------------------------------------------------------------------
// Chained hash table RAM
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module cht_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== hw/rtl/chained_hash_table_core.sv =====
// ----------------------------------------------------------------------------
// Chained hash table core
// Key/value table with one chain of nodes per bucket, held in block RAMs.
// ----------------------------------------------------------------------------
// Channel | direction | beat contents
// in      | input     | cmd_i, lookup_key_i, store_value_i
// out     | output    | read_value_o, hit_o, status_o
//
// One operation at a time. After the accepting edge, S_HEAD reads the bucket
// head, S_CMP compares the first node, and each further node passes through
// S_NODE (key/link re-read), then S_CMP; the single port of each RAM sets this.
// A hit on a get or a put needs nothing more, a remove hit a write-back in
// S_FREEW, a miss a pass through S_FREE and a put of a new key S_FREEW to link
// the node; S_DONE then posts the result beat. An unused command goes straight there.
// After reset a clearing pass writes null to every bucket head, during which
// in_ready_o stays low.
// A result beat waits in an output register; the next beat is not taken
// until it has gone, so a stalled output simply holds the block.
// ----------------------------------------------------------------------------
module chained_hash_table_core
  import cht_pkg::*;
#(
  parameter int unsigned BUCKETS = DefBuckets,
  parameter int unsigned NODES   = DefNodes
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         cmd_i,
  input  logic signed [31:0] lookup_key_i,
  input  logic signed [31:0] store_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] read_value_o,
  output logic               hit_o,
  output logic               status_o
);
  // Links are node index + 1, zero meaning null.
  localparam int unsigned LW = $clog2(NODES + 1);
  localparam int unsigned NW = $clog2(NODES);
  localparam int unsigned BW = $clog2(BUCKETS);
  localparam int unsigned SW = $clog2(NODES + 1);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_HEAD  = 4'd2;
  localparam logic [3:0] S_NODE  = 4'd3;
  localparam logic [3:0] S_CMP   = 4'd4;
  localparam logic [3:0] S_FREE  = 4'd5;
  localparam logic [3:0] S_FREEW = 4'd6;
  localparam logic [3:0] S_DONE  = 4'd7;

  logic [3:0] state_q, state_d;
  logic [BW:0] clr_q, clr_d;
  logic [1:0] cmd_q;
  logic [31:0] key_q, val_q;
  logic [BW-1:0] bkt_q;
  logic [LW-1:0] cur_q, cur_d, prev_q, prev_d, head_q, head_d;
  logic [SW-1:0] steps_q, steps_d;
  logic [LW-1:0] fresh_q, fresh_d, recyc_q, recyc_d, newn_q, newn_d;
  logic out_v_q, out_v_d;
  logic [31:0] rd_q, rd_d;
  logic hit_q, hit_d, st_q, st_d;

  // RAM ports
  logic hd_we; logic [BW-1:0] hd_a; logic [LW-1:0] hd_wd, hd_rd;
  logic k_we;  logic [NW-1:0] n_a;  logic [31:0] k_rd;
  logic v_we;  logic [31:0] v_rd;
  logic l_we;  logic [LW-1:0] l_wd, l_rd;

  cht_ram #(.Width(LW), .Depth(BUCKETS)) u_heads (
    .clk_i, .we_i(hd_we), .addr_i(hd_a), .wdata_i(hd_wd), .rdata_o(hd_rd));
  cht_ram #(.Width(32), .Depth(NODES)) u_keys (
    .clk_i, .we_i(k_we), .addr_i(n_a), .wdata_i(key_q), .rdata_o(k_rd));
  cht_ram #(.Width(32), .Depth(NODES)) u_vals (
    .clk_i, .we_i(v_we), .addr_i(n_a), .wdata_i(val_q), .rdata_o(v_rd));
  cht_ram #(.Width(LW), .Depth(NODES)) u_links (
    .clk_i, .we_i(l_we), .addr_i(n_a), .wdata_i(l_wd), .rdata_o(l_rd));

  // Signed modulo by a power-of-two bucket count is the low bits; the
  // two's complement mask already gives the non-negative remainder.
  logic [BW-1:0] in_bkt;
  assign in_bkt = BW'(32'(lookup_key_i) % 32'(BUCKETS));

  function automatic logic lok(input logic [LW-1:0] l);
    return (l != '0) && ({1'b0, l} <= (LW+1)'(NODES));
  endfunction

  function automatic logic [NW-1:0] idx(input logic [LW-1:0] l);
    return NW'(l - LW'(1));
  endfunction

  assign in_ready_o   = (state_q == S_IDLE) && !out_v_q;
  assign out_valid_o  = out_v_q;
  assign read_value_o = rd_q;
  assign hit_o        = hit_q;
  assign status_o     = st_q;

  logic found, walk_on, can_alloc;
  assign found   = (k_rd == key_q);
  assign walk_on = lok(l_rd) && (steps_q + SW'(1) < SW'(NODES));
  assign can_alloc = lok(recyc_q) || ({1'b0, fresh_q} < (LW+1)'(NODES));

  always_comb begin
    state_d = state_q; clr_d = clr_q;
    cur_d = cur_q; prev_d = prev_q; head_d = head_q; steps_d = steps_q;
    fresh_d = fresh_q; recyc_d = recyc_q; newn_d = newn_q;
    out_v_d = out_v_q && !out_ready_i;
    rd_d = rd_q; hit_d = hit_q; st_d = st_q;
    hd_we = 1'b0; hd_a = bkt_q; hd_wd = '0;
    k_we = 1'b0; v_we = 1'b0; l_we = 1'b0; l_wd = '0;
    n_a = idx(cur_q);
    case (state_q)
      S_CLEAR: begin
        hd_we = 1'b1; hd_a = BW'(clr_q);
        clr_d = clr_q + 1'b1;
        if (clr_q == (BW+1)'(BUCKETS - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        hd_a = in_bkt;
        if (in_valid_i && in_ready_o) begin
          steps_d = '0; prev_d = '0;
          rd_d = '0; hit_d = 1'b0; st_d = 1'b0;
          state_d = (cmd_i > CMD_REMOVE) ? S_DONE : S_HEAD;
        end
      end
      S_HEAD: begin
        head_d = hd_rd; cur_d = hd_rd;
        n_a = idx(hd_rd);
        state_d = lok(hd_rd) ? S_CMP : S_FREE;
      end
      S_NODE: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        if (found) begin
          hit_d = 1'b1;
          case (cmd_q)
            CMD_PUT: begin v_we = 1'b1; state_d = S_DONE; end
            CMD_GET: begin rd_d = v_rd; state_d = S_DONE; end
            default: begin
              // Unlink: bypass this node, then push it onto the free list.
              if (prev_q == '0) begin
                hd_we = 1'b1; hd_wd = l_rd;
              end else begin
                l_we = 1'b1; l_wd = l_rd; n_a = idx(prev_q);
              end
              state_d = S_FREEW;
            end
          endcase
        end else if (walk_on) begin
          prev_d = cur_q; cur_d = l_rd; steps_d = steps_q + SW'(1);
          n_a = idx(l_rd);
          state_d = S_NODE;
        end else begin
          state_d = S_FREE;
          n_a = idx(recyc_q);
        end
      end
      S_FREE: begin
        // Miss. For a put, read the free-list successor of the recycled head.
        n_a = idx(recyc_q);
        if (cmd_q != CMD_PUT) begin
          state_d = S_DONE;
        end else if (!can_alloc) begin
          st_d = 1'b1; state_d = S_DONE;
        end else if (lok(recyc_q)) begin
          newn_d = recyc_q; state_d = S_FREEW;
        end else begin
          fresh_d = fresh_q + 1'b1; newn_d = fresh_q + 1'b1;
          recyc_d = recyc_q; state_d = S_FREEW;
        end
      end
      S_FREEW: begin
        if (cmd_q == CMD_PUT) begin
          n_a = idx(newn_q);
          if (newn_q == recyc_q) recyc_d = l_rd;
          k_we = 1'b1; v_we = 1'b1; l_we = 1'b1; l_wd = head_q;
          hd_we = 1'b1; hd_wd = newn_q;
        end else begin
          l_we = 1'b1; l_wd = recyc_q; recyc_d = cur_q;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        out_v_d = 1'b1; state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR; clr_q <= '0; out_v_q <= 1'b0;
      fresh_q <= '0; recyc_q <= '0;
    end else begin
      state_q <= state_d; clr_q <= clr_d; out_v_q <= out_v_d;
      fresh_q <= fresh_d; recyc_q <= recyc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i && in_ready_o) begin
      cmd_q <= cmd_i; key_q <= lookup_key_i; val_q <= store_value_i;
      bkt_q <= in_bkt;
    end
    cur_q <= cur_d; prev_q <= prev_d; head_q <= head_d; steps_q <= steps_d;
    newn_q <= newn_d; rd_q <= rd_d; hit_q <= hit_d; st_q <= st_d;
  end

  a_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second beat taken during an operation");
  a_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, fresh_q} <= (LW+1)'(NODES))
    else $error("fresh count beyond pool");
  a_full_put: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> !hit_o)
    else $error("full flagged on a hit");
  a_get_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !hit_o) |-> (read_value_o == '0))
    else $error("value returned on a miss");
endmodule

// ===== tb/tb_chained_hash_table_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Chained hash table core testbench
// Drives put, get, remove and unused-command beats with random gaps, keeps a behavioural copy
// of the bucket chains and node pool, and checks every result beat against it.
// ----------------------------------------------------------------------------
module tb_chained_hash_table_core;
  import cht_pkg::*;

  localparam int unsigned NumBuckets = DefBuckets;
  localparam int unsigned NumNodes   = DefNodes;
  localparam logic [1:0]  CmdUnused  = 2'd3;
  localparam int unsigned NumRandom  = 930;
  localparam int unsigned StallLimit = 20000;

  typedef struct packed {
    logic signed [31:0] rd;
    logic               hit;
    logic               status;
  } result_t;

  typedef struct {
    logic [1:0]         cmd;
    logic signed [31:0] key;
    logic signed [31:0] val;
    bit                 typed;
    result_t            res;
  } stim_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         cmd_i;
  logic signed [31:0] lookup_key_i;
  logic signed [31:0] store_value_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [31:0] read_value_o;
  logic               hit_o;
  logic               status_o;

  chained_hash_table_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .lookup_key_i (lookup_key_i),
    .store_value_i(store_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .read_value_o (read_value_o),
    .hit_o        (hit_o),
    .status_o     (status_o)
  );

  initial begin
    clk_i = 1'b0;
  end
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow table: links are node index + 1, zero is null.
  int unsigned        shadow_heads[NumBuckets];
  logic signed [31:0] shadow_keys[NumNodes];
  logic signed [31:0] shadow_vals[NumNodes];
  int unsigned        shadow_links[NumNodes];
  int unsigned        shadow_fresh;
  int unsigned        shadow_free;

  result_t     pending_results[$];
  logic signed [31:0] used_keys[$];
  int unsigned error_count;
  int unsigned idle_cycles;
  bit          stim_done;

  task automatic report_mismatch(input string what);
    error_count++;
    $display("%0t mismatch: %s", $realtime, what);
  endtask

  function automatic int unsigned bucket_of(logic signed [31:0] key);
    int r;
    r = key % int'(NumBuckets);
    if (r < 0) r += NumBuckets;
    return r;
  endfunction

  // Applies one operation to the shadow table and returns the result beat.
  function automatic result_t table_apply(logic [1:0] cmd, logic signed [31:0] key,
                                          logic signed [31:0] val);
    result_t     res;
    int unsigned b, cur, prev, steps, node;
    bit          found;
    res = '0;
    b = bucket_of(key);
    cur = shadow_heads[b];
    prev = 0;
    steps = 0;
    found = 1'b0;
    if (cmd == CmdUnused) return res;
    while (cur != 0 && cur <= NumNodes && steps < NumNodes) begin
      if (shadow_keys[cur-1] == key) begin
        found = 1'b1;
        break;
      end
      prev = cur;
      cur = shadow_links[cur-1];
      steps++;
    end
    case (cmd)
      CMD_PUT: begin
        if (found) begin
          shadow_vals[cur-1] = val;
          res.hit = 1'b1;
        end else begin
          node = 0;
          if (shadow_free != 0) begin
            node = shadow_free;
            shadow_free = shadow_links[node-1];
          end else if (shadow_fresh < NumNodes) begin
            shadow_fresh++;
            node = shadow_fresh;
          end
          if (node != 0) begin
            shadow_keys[node-1] = key;
            shadow_vals[node-1] = val;
            shadow_links[node-1] = shadow_heads[b];
            shadow_heads[b] = node;
          end else begin
            res.status = 1'b1;
          end
        end
      end
      CMD_GET: begin
        if (found) begin
          res.rd = shadow_vals[cur-1];
          res.hit = 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (found) begin
          if (prev == 0) shadow_heads[b] = shadow_links[cur-1];
          else shadow_links[prev-1] = shadow_links[cur-1];
          shadow_links[cur-1] = shadow_free;
          shadow_free = cur;
          res.hit = 1'b1;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Sends one beat; the expectation is queued at the accepting edge. Valid is
  // only dropped when a gap follows, so back-to-back beats keep it high.
  task automatic send_op(input logic [1:0] cmd, input logic signed [31:0] key,
                         input logic signed [31:0] val, input bit typed,
                         input result_t typed_res);
    int unsigned gap;
    result_t     res;
    gap = $urandom_range(0, 5);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    cmd_i         <= cmd;
    lookup_key_i  <= key;
    store_value_i <= val;
    do @(posedge clk_i); while (!in_ready_o);
    res = table_apply(cmd, key, val);
    if (typed && res != typed_res) report_mismatch("typed row disagrees with predictor");
    pending_results.push_back(typed ? typed_res : res);
    if (cmd == CMD_PUT) used_keys.push_back(key);
  endtask

  // Output side: random stall drawn per beat, and the checker.
  initial begin : result_sink
    int unsigned stall;
    result_t     exp_res;
    out_ready_i = 1'b0;
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        exp_res = pending_results.pop_front();
        if (read_value_o !== exp_res.rd)
          report_mismatch($sformatf("read_value %0d, expected %0d", read_value_o, exp_res.rd));
        if (hit_o !== exp_res.hit)
          report_mismatch($sformatf("hit %b, expected %b", hit_o, exp_res.hit));
        if (status_o !== exp_res.status)
          report_mismatch($sformatf("status %b, expected %b", status_o, exp_res.status));
      end
    end
  end

  // Watchdog on cycles without any accepted beat; allows for the clearing pass.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic signed [31:0] pick_key();
    if (used_keys.size() != 0 && $urandom_range(0, 3) != 0)
      return used_keys[$urandom_range(0, used_keys.size() - 1)];
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $signed(32'($urandom_range(0, 2047)));
      2: return -$signed(32'($urandom_range(0, 2047)));
      default: return $signed(32'($urandom_range(0, 15) * NumBuckets));
    endcase
  endfunction

  initial begin : stimulus
    stim_row_t   rows[$];
    result_t     r0;
    logic [1:0]  cmd;
    int unsigned sel;
    r0 = '0;
    error_count = 0;
    idle_cycles = 0;
    stim_done = 1'b0;
    for (int i = 0; i < NumBuckets; i++) shadow_heads[i] = 0;
    for (int i = 0; i < NumNodes; i++) begin
      shadow_keys[i] = '0;
      shadow_vals[i] = '0;
      shadow_links[i] = 0;
    end
    shadow_fresh = 0;
    shadow_free = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    cmd_i = CMD_GET;
    lookup_key_i = '0;
    store_value_i = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows: empty table, extremes, collisions in one bucket, unused
    // command, removal in the middle of a chain and reuse of a freed node.
    rows = '{
      '{CMD_GET,    32'sh8000_0000, 32'sd0,          1'b1, '{32'sd0, 1'b0, 1'b0}},
      '{CMD_REMOVE, 32'sd5,         32'sd0,          1'b1, '{32'sd0, 1'b0, 1'b0}},
      '{CMD_PUT,    32'sh8000_0000, 32'sh7fff_ffff,  1'b1, '{32'sd0, 1'b0, 1'b0}},
      '{CMD_PUT,    32'sh7fff_ffff, 32'sh8000_0000,  1'b1, '{32'sd0, 1'b0, 1'b0}},
      '{CMD_GET,    32'sh8000_0000, 32'sd0,          1'b1, '{32'sh7fff_ffff, 1'b1, 1'b0}},
      '{CMD_GET,    32'sh7fff_ffff, 32'sd0,          1'b1, '{32'sh8000_0000, 1'b1, 1'b0}},
      '{CMD_PUT,    32'sh7fff_ffff, -32'sd1,         1'b1, '{32'sd0, 1'b1, 1'b0}},
      '{CMD_GET,    32'sh7fff_ffff, 32'sd0,          1'b1, '{-32'sd1, 1'b1, 1'b0}},
      '{CMD_PUT,    32'sd0,         32'sd10,         1'b0, r0},
      '{CMD_PUT,    32'sd256,       32'sd11,         1'b0, r0},
      '{CMD_PUT,    -32'sd256,      32'sd12,         1'b0, r0},
      '{CMD_PUT,    -32'sd1,        32'sd13,         1'b0, r0},
      '{CmdUnused,  32'sd0,         32'sd99,         1'b1, '{32'sd0, 1'b0, 1'b0}},
      '{CMD_REMOVE, 32'sd256,       32'sd0,          1'b1, '{32'sd0, 1'b1, 1'b0}},
      '{CMD_GET,    32'sd256,       32'sd0,          1'b1, '{32'sd0, 1'b0, 1'b0}},
      '{CMD_GET,    32'sd0,         32'sd0,          1'b0, r0},
      '{CMD_GET,    -32'sd256,      32'sd0,          1'b0, r0},
      '{CMD_PUT,    32'sd512,       32'sd14,         1'b0, r0},
      '{CMD_REMOVE, 32'sd512,       32'sd0,          1'b0, r0},
      '{CMD_REMOVE, 32'sd512,       32'sd0,          1'b1, '{32'sd0, 1'b0, 1'b0}},
      '{CMD_GET,    -32'sd1,        32'sd0,          1'b0, r0}
    };
    foreach (rows[i]) send_op(rows[i].cmd, rows[i].key, rows[i].val, rows[i].typed, rows[i].res);

    // Random mix, mostly keys already seen so gets and removes often hit.
    for (int i = 0; i < NumRandom; i++) begin
      sel = $urandom_range(0, 19);
      cmd = (sel < 8) ? CMD_PUT : (sel < 14) ? CMD_GET : (sel < 19) ? CMD_REMOVE : CmdUnused;
      send_op(cmd, pick_key(), $urandom, 1'b0, r0);
    end
    in_valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin : finish_run
    wait (stim_done);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
